// ===== src/mi3_pkg.sv =====
// Shared types and constants for the 3x3 adjugate matrix inverse.
// Used by every module of the block; depends on nothing.
package mi3_pkg;

   // Element format, fixed by the item fields
   localparam int ELEM_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   // Cofactor, determinant, divider working widths
   localparam int COF_WIDTH = 2 * ELEM_WIDTH + 1;
   localparam int DET_WIDTH = 3 * ELEM_WIDTH + 3;
   localparam int NUM_A     = 2 * ELEM_WIDTH + 2 * FRAC_BITS + 2;
   localparam int NUM_WIDTH = ((NUM_A > DET_WIDTH) ? NUM_A : DET_WIDTH) + 1;
   localparam int SHD_WIDTH = DET_WIDTH + ELEM_WIDTH + 1;
   localparam int DIV_WIDTH = (NUM_WIDTH > SHD_WIDTH) ? NUM_WIDTH : SHD_WIDTH;

   localparam int          NUM_ELEMS = 9;
   localparam int          NUM_PRODS = 18;
   localparam logic [3:0]  LAST_ELEM = 4'd8;

   // Operand pairs of the eighteen two-term products; cofactor i is
   // product 2i minus product 2i+1
   localparam logic [3:0] MUL_A [NUM_PRODS] = '{
      4'd4, 4'd7, 4'd6, 4'd3, 4'd3, 4'd6, 4'd7, 4'd1, 4'd0,
      4'd6, 4'd6, 4'd0, 4'd1, 4'd4, 4'd3, 4'd0, 4'd0, 4'd3};
   localparam logic [3:0] MUL_B [NUM_PRODS] = '{
      4'd8, 4'd5, 4'd5, 4'd8, 4'd7, 4'd4, 4'd2, 4'd8, 4'd8,
      4'd2, 4'd1, 4'd7, 4'd5, 4'd2, 4'd2, 4'd5, 4'd4, 4'd1};

   typedef struct packed {
      logic signed [ELEM_WIDTH-1:0] in_r0c0;
      logic signed [ELEM_WIDTH-1:0] in_r0c1;
      logic signed [ELEM_WIDTH-1:0] in_r0c2;
      logic signed [ELEM_WIDTH-1:0] in_r1c0;
      logic signed [ELEM_WIDTH-1:0] in_r1c1;
      logic signed [ELEM_WIDTH-1:0] in_r1c2;
      logic signed [ELEM_WIDTH-1:0] in_r2c0;
      logic signed [ELEM_WIDTH-1:0] in_r2c1;
      logic signed [ELEM_WIDTH-1:0] in_r2c2;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_WIDTH-1:0] inv_r0c0;
      logic signed [ELEM_WIDTH-1:0] inv_r0c1;
      logic signed [ELEM_WIDTH-1:0] inv_r0c2;
      logic signed [ELEM_WIDTH-1:0] inv_r1c0;
      logic signed [ELEM_WIDTH-1:0] inv_r1c1;
      logic signed [ELEM_WIDTH-1:0] inv_r1c2;
      logic signed [ELEM_WIDTH-1:0] inv_r2c0;
      logic signed [ELEM_WIDTH-1:0] inv_r2c1;
      logic signed [ELEM_WIDTH-1:0] inv_r2c2;
      logic                         singular;
      logic                         saturated;
   } rsp_type;

   // One classified matrix: exact cofactors and determinant
   typedef struct packed {
      logic [NUM_ELEMS-1:0][COF_WIDTH-1:0] cof;
      logic [DET_WIDTH-1:0]                det;
   } work_type;

   // Output element k (row-major) takes the transposed cofactor
   function automatic logic [3:0] adj_index(input logic [3:0] k);
      logic [3:0] idx;
      case (k)
         4'd0:    idx = 4'd0;
         4'd1:    idx = 4'd3;
         4'd2:    idx = 4'd6;
         4'd3:    idx = 4'd1;
         4'd4:    idx = 4'd4;
         4'd5:    idx = 4'd7;
         4'd6:    idx = 4'd2;
         4'd7:    idx = 4'd5;
         4'd8:    idx = 4'd8;
         default: idx = 4'd0;
      endcase
      return idx;
   endfunction

endpackage

// ===== src/mi3_front.sv =====
// Front pipeline: products, cofactors and determinant of one matrix a cycle, unless a full queue stalls it.
// Depends on mi3_pkg.
module mi3_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  mi3_pkg::req_type  req_data,
   output logic              wr_valid,
   input  logic              wr_full,
   output mi3_pkg::work_type wr_data
);

   localparam int EW = mi3_pkg::ELEM_WIDTH;
   localparam int CW = mi3_pkg::COF_WIDTH;
   localparam int DW = mi3_pkg::DET_WIDTH;

   logic signed [EW-1:0]   m [9];
   logic                   adv;

   logic                   v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic signed [2*EW-1:0] prod_ff [mi3_pkg::NUM_PRODS];
   logic signed [2*EW-1:0] prod_in [mi3_pkg::NUM_PRODS];
   logic signed [EW-1:0]   row1_ff [3];
   logic signed [EW-1:0]   row2_ff [3];
   logic signed [CW-1:0]   cof2_ff [mi3_pkg::NUM_ELEMS];
   logic signed [CW-1:0]   cof2_in [mi3_pkg::NUM_ELEMS];
   logic signed [CW-1:0]   cof3_ff [mi3_pkg::NUM_ELEMS];
   logic signed [2*EW:0]   pl_ff [3], pl_in [3], ph_ff [3], ph_in [3];
   logic signed [DW-1:0]   pl_sum, ph_sum, det;

   assign m[0] = req_data.in_r0c0;
   assign m[1] = req_data.in_r0c1;
   assign m[2] = req_data.in_r0c2;
   assign m[3] = req_data.in_r1c0;
   assign m[4] = req_data.in_r1c1;
   assign m[5] = req_data.in_r1c2;
   assign m[6] = req_data.in_r2c0;
   assign m[7] = req_data.in_r2c1;
   assign m[8] = req_data.in_r2c2;

   // Whole pipeline moves unless the last stage is blocked by the queue
   assign adv   = !v3_ff || !wr_full;
   assign full  = !adv;
   assign v1_in = adv ? push  : v1_ff;
   assign v2_in = adv ? v1_ff : v2_ff;
   assign v3_in = adv ? v2_ff : v3_ff;

   // Stage 1: the eighteen element products
   always_comb begin
      for (int i = 0; i < mi3_pkg::NUM_PRODS; i++) begin
         prod_in[i] = m[mi3_pkg::MUL_A[i]] * m[mi3_pkg::MUL_B[i]];
      end
   end

   // Stage 2: cofactors, exact
   always_comb begin
      for (int i = 0; i < mi3_pkg::NUM_ELEMS; i++) begin
         cof2_in[i] = CW'(prod_ff[2*i]) - CW'(prod_ff[2*i+1]);
      end
   end

   // Stage 3: row-0 expansion, cofactor split into low and high halves
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         pl_in[j] = row2_ff[j] * $signed({1'b0, cof2_ff[j][EW-1:0]});
         ph_in[j] = row2_ff[j] * $signed(cof2_ff[j][CW-1:EW]);
      end
   end

   // Determinant from the registered partial products
   assign pl_sum = DW'(pl_ff[0]) + DW'(pl_ff[1]) + DW'(pl_ff[2]);
   assign ph_sum = DW'(ph_ff[0]) + DW'(ph_ff[1]) + DW'(ph_ff[2]);
   assign det    = pl_sum + (ph_sum <<< EW);

   always_comb begin
      for (int i = 0; i < mi3_pkg::NUM_ELEMS; i++) begin
         wr_data.cof[i] = cof3_ff[i];
      end
      wr_data.det = det;
   end
   assign wr_valid = v3_ff;

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         row1_ff <= '{m[0], m[1], m[2]};
         row2_ff <= row1_ff;
         cof2_ff <= cof2_in;
         cof3_ff <= cof2_ff;
         pl_ff   <= pl_in;
         ph_ff   <= ph_in;
      end
   end

endmodule

// ===== src/mi3_queue.sv =====
// Short queue of classified matrices between the front and back parts.
// Depends on mi3_pkg.
module mi3_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_full,
   input  mi3_pkg::work_type wr_data,
   output logic              rd_empty,
   input  logic              rd_pop,
   output mi3_pkg::work_type rd_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CNW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0]  LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CNW-1:0] FULL_CNT = CNW'(DEPTH);

   mi3_pkg::work_type mem [DEPTH];
   logic [PW-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [CNW-1:0]    cnt_ff, cnt_in;
   logic              do_wr, do_rd;

   assign wr_full  = (cnt_ff == FULL_CNT);
   assign rd_empty = (cnt_ff == '0);
   assign do_wr    = wr_valid && !wr_full;
   assign do_rd    = rd_pop && !rd_empty;
   assign rd_data  = mem[rp_ff];

   // Pointer and fill count update
   always_comb begin
      wp_in  = do_wr ? ((wp_ff == LAST_PTR) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in  = do_rd ? ((rp_ff == LAST_PTR) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + CNW'(do_wr) - CNW'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wp_ff] <= wr_data;
      end
   end

endmodule

// ===== src/mi3_back.sv =====
// Back part: one shared restoring divider forms the nine inverse elements,
// rounds, saturates and holds the result. Depends on mi3_pkg.
module mi3_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   output logic              q_pop,
   input  mi3_pkg::work_type head,
   output logic              empty,
   input  logic              pop,
   output mi3_pkg::rsp_type  rsp_data
);

   localparam int EW  = mi3_pkg::ELEM_WIDTH;
   localparam int CW  = mi3_pkg::COF_WIDTH;
   localparam int DW  = mi3_pkg::DET_WIDTH;
   localparam int XW  = mi3_pkg::DIV_WIDTH;
   localparam int SBW = $clog2(EW + 1);
   localparam logic [SBW-1:0] FIRST_STEP = SBW'(EW);
   localparam logic [EW:0]    POS_LIM = {2'b00, {(EW-1){1'b1}}};
   localparam logic [EW:0]    NEG_LIM = {2'b01, {(EW-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } back_state_type;

   back_state_type       state_ff, state_in;
   logic [3:0]           k_ff, k_in;
   logic [SBW-1:0]       step_ff, step_in;
   logic [XW-1:0]        rem_ff, rem_in, dsh_ff, dsh_in;
   logic [EW:0]          quo_ff, quo_in;
   logic                 neg_ff, neg_in, sat_ff, sat_in;
   logic [EW-1:0]        inv_ff [mi3_pkg::NUM_ELEMS];
   logic                 inv_we;
   logic [EW-1:0]        inv_val;
   mi3_pkg::rsp_type     out_ff, out_in;
   logic                 ov_ff, ov_in, out_we, out_free;

   logic signed [DW-1:0] det;
   logic                 dneg, det_zero;
   logic [DW-1:0]        adet;
   logic signed [CW-1:0] cof;
   logic [CW-1:0]        cabs;
   logic                 ge, over;
   logic [EW:0]          lim, qclip, qneg;

   // Determinant and selected cofactor from the queue head
   assign det      = $signed(head.det);
   assign dneg     = det[DW-1];
   assign det_zero = (det == '0);
   assign adet     = dneg ? DW'(-det) : DW'(det);
   assign cof      = $signed(head.cof[mi3_pkg::adj_index(k_ff)]);
   assign cabs     = cof[CW-1] ? CW'(-cof) : CW'(cof);

   // One quotient bit per cycle
   assign ge     = (rem_ff >= dsh_ff);
   assign quo_in = (state_ff == ST_DIV) ? {quo_ff[EW-1:0], ge} : '0;

   // Saturate and apply sign to the finished quotient
   assign lim     = neg_ff ? NEG_LIM : POS_LIM;
   assign over    = (quo_in > lim);
   assign qclip   = over ? lim : quo_in;
   assign qneg    = neg_ff ? (~qclip + 1'b1) : qclip;
   assign inv_val = qneg[EW-1:0];

   assign out_free = !ov_ff || pop;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      neg_in   = neg_ff;
      sat_in   = sat_ff;
      inv_we   = 1'b0;
      out_we   = 1'b0;
      q_pop    = 1'b0;
      out_in   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               if (det_zero) begin
                  if (out_free) begin
                     out_in.singular = 1'b1;
                     out_we = 1'b1;
                     q_pop  = 1'b1;
                  end
               end else begin
                  k_in     = '0;
                  sat_in   = 1'b0;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            rem_in   = (XW'(cabs) << (2 * mi3_pkg::FRAC_BITS + 1)) + XW'(adet);
            dsh_in   = XW'(adet) << (EW + 1);
            neg_in   = cof[CW-1] ^ dneg;
            step_in  = FIRST_STEP;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (ge) begin
               rem_in = rem_ff - dsh_ff;
            end
            dsh_in = dsh_ff >> 1;
            if (step_ff == '0) begin
               inv_we = 1'b1;
               sat_in = sat_ff | over;
               if (k_ff == mi3_pkg::LAST_ELEM) begin
                  state_in = ST_DONE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_LOAD;
               end
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_in.inv_r0c0  = inv_ff[0];
               out_in.inv_r0c1  = inv_ff[1];
               out_in.inv_r0c2  = inv_ff[2];
               out_in.inv_r1c0  = inv_ff[3];
               out_in.inv_r1c1  = inv_ff[4];
               out_in.inv_r1c2  = inv_ff[5];
               out_in.inv_r2c0  = inv_ff[6];
               out_in.inv_r2c1  = inv_ff[7];
               out_in.inv_r2c2  = inv_ff[8];
               out_in.saturated = sat_ff;
               out_we   = 1'b1;
               q_pop    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register, freed by a transfer
   assign ov_in    = out_we ? 1'b1 : (pop ? 1'b0 : ov_ff);
   assign empty    = !ov_ff;
   assign rsp_data = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      sat_ff  <= sat_in;
      if (inv_we) begin
         inv_ff[k_ff] <= inv_val;
      end
      if (out_we) begin
         out_ff <= out_in;
      end
   end

   // Queue head is only released when present
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

   // A singular result never reports clipping
   a_sing_nosat: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && out_ff.singular) |-> !out_ff.saturated)
      else $error("singular result flagged saturated");

   // Element counter stays within the matrix while dividing
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV || state_ff == ST_LOAD) |-> (k_ff <= mi3_pkg::LAST_ELEM))
      else $error("element index out of range");

endmodule

// ===== src/matrix_inverse_3x3.sv =====
// 3x3 matrix inverse by the adjugate, Q16.16 in and out with rounding and
// saturation. Depends on mi3_pkg, mi3_front, mi3_queue and mi3_back.
//
// The front pipeline takes one matrix per cycle unless a full queue stalls it
// and, through its product, cofactor and partial-product registers, places its
// exact cofactors and determinant in a queue of QUEUE_DEPTH entries. The back
// part divides with a single restoring divider, one quotient bit a cycle: each
// of the nine elements takes one load step and 33 quotient bits, and a singular
// matrix is answered from the idle state alone. That shared divider sets the
// sustained rate; the front keeps accepting until the queue fills, and a
// finished result waits in its own output register.
module matrix_inverse_3x3 #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  mi3_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output mi3_pkg::rsp_type rsp_data
);

   logic              wr_valid, wr_full, q_empty, q_pop;
   mi3_pkg::work_type wr_data, head;

   mi3_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .wr_valid (wr_valid),
      .wr_full  (wr_full),
      .wr_data  (wr_data)
   );

   mi3_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (wr_valid),
      .wr_full  (wr_full),
      .wr_data  (wr_data),
      .rd_empty (q_empty),
      .rd_pop   (q_pop),
      .rd_data  (head)
   );

   mi3_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .head     (head),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for matrix_inverse_3x3: queued Q16.16 matrices in, inverses checked against
// an exact wide-integer prediction of the adjugate divided by the determinant.
// Depends on mi3_pkg and the matrix_inverse_3x3 RTL.
`timescale 1ns / 100ps

module testbench;

   typedef logic signed [255:0] wide_type;
   typedef logic signed [31:0] elem_type;

   localparam int HOLD_CYCLES = 3000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             push = 1'b0;
   logic             pop = 1'b0;
   logic             full, empty;
   mi3_pkg::req_type req_data = '0;
   mi3_pkg::rsp_type rsp_data;

   mi3_pkg::req_type pending_matrices[$];
   mi3_pkg::rsp_type inverse_queue[$];
   int      fail_count = 0;
   int      send_idle_pct = 37;
   int      recv_idle_pct = 78;
   bit      hold_start = 1'b0;
   int      hold_count = 0;
   string   field_names[9] = '{"inv_r0c0", "inv_r0c1", "inv_r0c2", "inv_r1c0", "inv_r1c1",
                               "inv_r1c2", "inv_r2c0", "inv_r2c1", "inv_r2c2"};

   matrix_inverse_3x3 i_dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data));

   // Clock, 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Exact inverse: adjugate over determinant, rounded half away from zero, clipped
   function automatic mi3_pkg::rsp_type invert_matrix(input mi3_pkg::req_type m);
      wide_type e[9];
      wide_type cof[9];
      wide_type det, adet, c, num, q;
      elem_type o[9];
      logic     neg, sat;
      int       adj[9] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};
      for (int k = 0; k < 9; k++) e[k] = wide_type'(elem_type'(m[287 - 32*k -: 32]));
      cof[0] = e[4]*e[8] - e[7]*e[5];
      cof[1] = e[6]*e[5] - e[3]*e[8];
      cof[2] = e[3]*e[7] - e[6]*e[4];
      cof[3] = e[7]*e[2] - e[1]*e[8];
      cof[4] = e[0]*e[8] - e[6]*e[2];
      cof[5] = e[6]*e[1] - e[0]*e[7];
      cof[6] = e[1]*e[5] - e[4]*e[2];
      cof[7] = e[3]*e[2] - e[0]*e[5];
      cof[8] = e[0]*e[4] - e[3]*e[1];
      det = e[0]*cof[0] + e[1]*cof[1] + e[2]*cof[2];
      if (det == 0) return {288'd0, 1'b1, 1'b0};
      adet = (det < 0) ? -det : det;
      sat = 1'b0;
      for (int k = 0; k < 9; k++) begin
         c = cof[adj[k]];
         neg = (c < 0) != (det < 0);
         num = (((c < 0) ? -c : c) <<< (2*mi3_pkg::FRAC_BITS + 1)) + adet;
         q = num / (adet <<< 1);
         if (neg && q > (wide_type'(1) <<< 31)) begin
            q = wide_type'(1) <<< 31;
            sat = 1'b1;
         end else if (!neg && q > (wide_type'(1) <<< 31) - 1) begin
            q = (wide_type'(1) <<< 31) - 1;
            sat = 1'b1;
         end
         o[k] = neg ? elem_type'(-q) : elem_type'(q);
      end
      return {o[0], o[1], o[2], o[3], o[4], o[5], o[6], o[7], o[8], 1'b0, sat};
   endfunction

   function automatic mi3_pkg::req_type make_matrix(input elem_type a0, a1, a2, a3, a4,
                                                    a5, a6, a7, a8);
      return {a0, a1, a2, a3, a4, a5, a6, a7, a8};
   endfunction

   function automatic elem_type rand_full();
      return elem_type'($urandom);
   endfunction

   function automatic elem_type rand_range(input int bits);
      elem_type v;
      v = elem_type'($urandom_range((1 << bits) - 1));
      return $urandom_range(1) ? -v : v;
   endfunction

   // Random matrix, half well conditioned, with singular, tiny and full-range mixes
   function automatic mi3_pkg::req_type rand_matrix();
      elem_type a[9];
      int       sel, bits;
      sel = $urandom_range(99);
      bits = $urandom_range(4, 30);
      for (int k = 0; k < 9; k++) begin
         if (sel < 50) a[k] = rand_range(17);
         else if (sel < 65) a[k] = rand_full();
         else if (sel < 75) a[k] = rand_range(6);
         else a[k] = rand_range(bits);
      end
      // Diagonally dominant for the first group
      if (sel < 50) for (int k = 0; k < 9; k += 4) a[k] = a[k] + rand_range(20);
      // Singular: copy a row, or a zero column
      if (sel >= 85 && sel < 93) for (int k = 0; k < 3; k++) a[6 + k] = a[$urandom_range(1)*3 + k];
      if (sel >= 93) for (int r = 0; r < 3; r++) a[r*3 + 1] = '0;
      return make_matrix(a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7], a[8]);
   endfunction

   // Driver: present a new matrix after each transfer, with random gaps
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) inverse_queue.push_back(invert_matrix(req_data));
         if (!push || !full) begin
            if (pending_matrices.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending_matrices.pop_front();
               push <= 1'b1;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here once started
   always @(posedge clock) begin
      if (hold_start && hold_count < HOLD_CYCLES) hold_count <= hold_count + 1;
   end

   // Monitor: random pops, compare each transfer with the oldest prediction
   always @(posedge clock) begin
      mi3_pkg::rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (inverse_queue.size() == 0) begin
               $error("unexpected result %h", rsp_data);
               fail_count++;
            end else begin
               want = inverse_queue.pop_front();
               for (int k = 0; k < 9; k++)
                  if (want[289 - 32*k -: 32] !== rsp_data[289 - 32*k -: 32]) begin
                     $error("%s expected %h got %h", field_names[k], want[289 - 32*k -: 32],
                            rsp_data[289 - 32*k -: 32]);
                     fail_count++;
                  end
               if (want.singular !== rsp_data.singular) begin
                  $error("singular expected %b got %b", want.singular, rsp_data.singular);
                  fail_count++;
               end
               if (want.saturated !== rsp_data.saturated) begin
                  $error("saturated expected %b got %b", want.saturated, rsp_data.saturated);
                  fail_count++;
               end
            end
         end
         pop <= !(hold_start && hold_count < HOLD_CYCLES) && $urandom_range(99) >= recv_idle_pct;
      end
   end

   task automatic drain();
      while (pending_matrices.size() > 0 || push || inverse_queue.size() > 0) @(posedge clock);
   endtask

   // Stimulus and end of run
   initial begin
      elem_type one, mx, mn;
      one = 32'sh0001_0000;
      mx = 32'sh7fff_ffff;
      mn = 32'sh8000_0000;
      pending_matrices.push_back(make_matrix(one, 0, 0, 0, one, 0, 0, 0, one));
      pending_matrices.push_back(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_matrices.push_back(make_matrix(mx, mx, mx, mx, mx, mx, mx, mx, mx));
      pending_matrices.push_back(make_matrix(mn, mn, mn, mn, mn, mn, mn, mn, mn));
      pending_matrices.push_back(make_matrix(mx, 0, 0, 0, mx, 0, 0, 0, mx));
      pending_matrices.push_back(make_matrix(mn, 0, 0, 0, mn, 0, 0, 0, mn));
      pending_matrices.push_back(make_matrix(mn, mx, 0, mx, mn, 0, 0, 0, mx));
      pending_matrices.push_back(make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
      pending_matrices.push_back(make_matrix(-1, 0, 0, 0, -1, 0, 0, 0, -1));
      pending_matrices.push_back(make_matrix(3, 0, 0, 0, one, 0, 0, 0, -one));
      pending_matrices.push_back(make_matrix(0, one, 0, one, 0, 0, 0, 0, one));
      pending_matrices.push_back(make_matrix(2*one, 0, 0, 0, 4*one, 0, 0, 0, -one/2));
      pending_matrices.push_back(make_matrix(3*one, one, 0, one, 3*one, 0, 0, 0, 3*one));
      pending_matrices.push_back(make_matrix(one, 2*one, 3*one, 4*one, 5*one, 6*one,
                                             7*one, 8*one, 9*one));
      pending_matrices.push_back(make_matrix(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555,
                                             32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa,
                                             32'sh1234_5678, 32'shedcb_a987, 32'sh0f0f_0f0f));
      for (int k = 0; k < 5; k++)
         pending_matrices.push_back(make_matrix(rand_full(), rand_full(), rand_full(),
                                                rand_full(), rand_full(), rand_full(),
                                                rand_full(), rand_full(), rand_full()));
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Sender gaps 37 %, receiver 78 %
      for (int k = 0; k < 260; k++) pending_matrices.push_back(rand_matrix());
      drain();
      // Swapped
      send_idle_pct = 78;
      recv_idle_pct = 37;
      for (int k = 0; k < 280; k++) pending_matrices.push_back(rand_matrix());
      drain();
      // No gaps, with one long receiver stall so the input backs up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int k = 0; k < 290; k++) pending_matrices.push_back(rand_matrix());
      hold_start = 1'b1;
      drain();
      repeat (700) @(posedge clock);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #6ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
src/mi3_pkg.sv
src/mi3_front.sv
src/mi3_queue.sv
src/mi3_back.sv
src/matrix_inverse_3x3.sv
tb/sv/testbench.sv
